FILE: sv/prr_pkg.sv
// Package for the perceptron reuse replacement unit.
// Holds shared constants and types; no dependencies.
package prr_pkg;

  localparam int FEATS = 6;
  localparam logic [63:0] WB_PC = 64'h0000_0000_1234_5678;
  localparam int TAG_SHIFT = 12 + 6;
  localparam logic signed [6:0] W_MIN = -7'sd32;
  localparam logic signed [6:0] W_MAX = 7'sd32;
  localparam logic signed [9:0] Y_MAX = 10'sd255;
  localparam logic signed [9:0] Y_MIN = -10'sd256;

  localparam logic [1:0] REG_MARGIN  = 2'd0;
  localparam logic [1:0] REG_REPLACE = 2'd1;
  localparam logic [1:0] REG_BYPASS  = 2'd2;

  localparam logic KIND_VICTIM = 1'b0;
  localparam logic KIND_UPDATE = 1'b1;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_CLEAR,
    ST_HREAD,
    ST_HCALC,
    ST_WREAD,
    ST_WSUM,
    ST_SETREAD,
    ST_DECIDE,
    ST_SREAD,
    ST_SDECIDE,
    ST_TREAD,
    ST_TWRITE,
    ST_YREAD,
    ST_YSUM,
    ST_SWRITE
  } state_e;

  // Saturating weight step.
  function automatic logic signed [6:0] wstep(logic signed [6:0] w, logic up);
    logic signed [6:0] r;
    r = w;
    if (up) begin
      if (w < W_MAX) r = w + 7'sd1;
    end else begin
      if (w > W_MIN) r = w - 7'sd1;
    end
    return r;
  endfunction

endpackage

FILE: sv/perceptron_reuse_replacement_unit.sv
// Top level of the perceptron reuse replacement unit.
// Depends on prr_pkg.
//
// One item is accepted at a time while busy is low; its single result is
// shown for one cycle on result_valid_o. A victim request or an update of an
// unsampled set holds busy through the thread history read, hash, weight
// read, weight sum, set read and decide steps, and no new item is taken
// until busy falls; the result is registered in the decide step. An
// update of a sampled set adds the sampler steps (row read, decide,
// weight read, weight write, re-read and re-sum of the new weights, row
// write) before busy falls; its result still comes from the decide step.
// After reset a clearing pass over max(NUM_SETS, sampler sets, TABLE_ENTRIES)
// entries initializes LRU, dead marks, weights, sampler rows and thread
// history; busy is high meanwhile. Configuration writes are taken at any time
// (ready is always high) and must only be made while idle. The receiver cannot stall.
module perceptron_reuse_replacement_unit #(
  parameter int NUM_SETS      = 1024,
  parameter int WAYS          = 16,
  parameter int TABLE_ENTRIES = 256,
  parameter int SAMPLER_WAYS  = 16,
  parameter int THREADS       = 16,
  parameter int SAMPLE_STRIDE = 16
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        start,
  output logic        busy,
  input  logic        cfg_valid_i,
  output logic        cfg_ready_o,
  input  logic [1:0]  cfg_index_i,
  input  logic [8:0]  cfg_data_i,
  input  logic        kind_i,
  input  logic [3:0]  thread_id_i,
  input  logic [9:0]  set_index_i,
  input  logic [3:0]  way_i,
  input  logic [63:0] pc_i,
  input  logic [63:0] phys_addr_i,
  input  logic [63:0] line_tag_i,
  input  logic        is_writeback_i,
  input  logic        cache_hit_i,
  output logic        result_valid_o,
  output logic [3:0]  victim_way_o,
  output logic        bypass_o,
  output logic        dead_victim_o
);
  import prr_pkg::*;

  localparam int SSETS = (NUM_SETS + SAMPLE_STRIDE - 1) / SAMPLE_STRIDE;
  localparam int SETW  = NUM_SETS > 1 ? $clog2(NUM_SETS) : 1;
  localparam int WYW   = $clog2(WAYS);
  localparam int TBW   = $clog2(TABLE_ENTRIES);
  localparam int SWW   = $clog2(SAMPLER_WAYS);
  localparam int SSW   = SSETS > 1 ? $clog2(SSETS) : 1;
  localparam int THW   = THREADS > 1 ? $clog2(THREADS) : 1;
  localparam int CLRN  = (NUM_SETS > TABLE_ENTRIES) ?
                         ((NUM_SETS > SSETS) ? NUM_SETS : SSETS) :
                         ((TABLE_ENTRIES > SSETS) ? TABLE_ENTRIES : SSETS);
  localparam int CLW   = $clog2(CLRN + 1);
  localparam int HW    = FEATS * TBW;

  typedef logic [WAYS-1:0][WYW-1:0] lru_row_t;
  typedef struct packed {
    logic [SAMPLER_WAYS-1:0]           valid;
    logic [SAMPLER_WAYS-1:0][63:0]     tag;
    logic [SAMPLER_WAYS-1:0][9:0]      outp;
    logic [SAMPLER_WAYS-1:0][HW-1:0]   hashes;
    logic [SAMPLER_WAYS-1:0][SWW-1:0]  lru;
  } srow_t;

  // ---------------- memories ----------------
  lru_row_t              lru_mem  [NUM_SETS];
  logic [WAYS-1:0]       dead_mem [NUM_SETS];
  logic [6:0]            wt_mem   [FEATS][TABLE_ENTRIES];
  srow_t                 smp_mem  [SSETS];
  logic                  sfull_mem[SSETS];
  logic [2:0][63:0]      hist_mem [THREADS];

  // ---------------- config ----------------
  logic [7:0] margin_q;
  logic signed [8:0] repl_q, byp_q;
  assign cfg_ready_o = 1'b1;
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      margin_q <= 8'd68;
      repl_q   <= 9'sd124;
      byp_q    <= 9'sd3;
    end else if (cfg_valid_i) begin
      unique case (cfg_index_i)
        REG_MARGIN:  margin_q <= cfg_data_i[7:0];
        REG_REPLACE: repl_q   <= cfg_data_i;
        REG_BYPASS:  byp_q    <= cfg_data_i;
        default: ;
      endcase
    end
  end

  // ---------------- item registers ----------------
  state_e state_q, state_d;
  logic [CLW-1:0] clr_q;
  logic kind_q, upd_q, samp_q;
  logic [THW-1:0] tid_q;
  logic [SETW-1:0] set_q;
  logic [WYW-1:0] way_q;
  logic [63:0] p_q, tag_q;
  logic [2:0][63:0] hist_q;
  logic [FEATS-1:0][TBW-1:0] h_q;
  logic [FEATS-1:0][6:0] w_q;
  logic signed [9:0] sum_q;
  lru_row_t lru_q;
  logic [WAYS-1:0] dead_q;
  srow_t srow_q;
  logic sfull_q;
  logic [SWW-1:0] sidx_q;
  logic strain_q, sdir_q;
  logic [FEATS-1:0][TBW-1:0] th_q;
  logic [SSW-1:0] sset_q;

  // thread/set/way taken modulo their counts
  logic [THW-1:0] tid_in;
  logic [SETW-1:0] set_in;
  logic [WYW-1:0] way_in;
  assign tid_in = THW'(32'(thread_id_i) % THREADS);
  assign set_in = SETW'(32'(set_index_i) % NUM_SETS);
  assign way_in = WYW'(32'(way_i) % WAYS);

  assign busy = (state_q != ST_IDLE);
  wire accept = start && !busy;

  // hashes
  logic [FEATS-1:0][TBW-1:0] h_calc;
  always_comb begin
    h_calc[0] = TBW'(p_q ^ (p_q >> 2));
    h_calc[1] = TBW'(p_q ^ (hist_q[0] >> 1));
    h_calc[2] = TBW'(p_q ^ (hist_q[1] >> 2));
    h_calc[3] = TBW'(p_q ^ (hist_q[2] >> 3));
    h_calc[4] = TBW'(p_q ^ (tag_q >> 4));
    h_calc[5] = TBW'(p_q ^ tag_q);
  end

  // weight sum over six registered weights
  logic signed [9:0] sum_calc;
  always_comb begin
    sum_calc = '0;
    for (int f = 0; f < FEATS; f++)
      sum_calc = sum_calc + 10'(signed'(w_q[f]));
  end

  // set decisions
  logic dead_found;
  logic [WYW-1:0] dead_way, lru_w;
  always_comb begin
    dead_found = 1'b0;
    dead_way = '0;
    lru_w = '0;
    for (int i = WAYS - 1; i >= 0; i--) begin
      if (dead_q[i]) begin
        dead_found = 1'b1;
        dead_way = WYW'(i);
      end
    end
    for (int i = WAYS - 1; i >= 0; i--)
      if (lru_q[i] == WYW'(WAYS - 1)) lru_w = WYW'(i);
  end

  lru_row_t lru_new;
  always_comb begin
    lru_new = lru_q;
    for (int i = 0; i < WAYS; i++)
      if (lru_q[i] < lru_q[way_q]) lru_new[i] = lru_q[i] + 1'b1;
    lru_new[way_q] = '0;
  end

  // sampler decisions
  logic s_hit, s_inv;
  logic [SWW-1:0] s_hidx, s_iidx, s_lidx;
  logic signed [9:0] theta;
  assign theta = signed'({2'b00, margin_q});
  always_comb begin
    s_hit = 1'b0; s_inv = 1'b0;
    s_hidx = '0; s_iidx = '0; s_lidx = '0;
    for (int i = SAMPLER_WAYS - 1; i >= 0; i--) begin
      if (srow_q.valid[i] && srow_q.tag[i] == tag_q) begin
        s_hit = 1'b1; s_hidx = SWW'(i);
      end
      if (!srow_q.valid[i]) begin
        s_inv = 1'b1; s_iidx = SWW'(i);
      end
      if (srow_q.lru[i] == SWW'(SAMPLER_WAYS - 1)) s_lidx = SWW'(i);
    end
  end

  // stored output: sum over the weights as they stand after training
  logic signed [9:0] y_clamp;
  always_comb begin
    if (sum_q > Y_MAX)      y_clamp = Y_MAX;
    else if (sum_q < Y_MIN) y_clamp = Y_MIN;
    else                    y_clamp = sum_q;
  end

  srow_t srow_new;
  always_comb begin
    srow_new = srow_q;
    for (int i = 0; i < SAMPLER_WAYS; i++)
      if (srow_q.lru[i] < srow_q.lru[sidx_q]) srow_new.lru[i] = srow_q.lru[i] + 1'b1;
    srow_new.lru[sidx_q]    = '0;
    srow_new.tag[sidx_q]    = tag_q;
    srow_new.valid[sidx_q]  = 1'b1;
    srow_new.hashes[sidx_q] = h_q;
    srow_new.outp[sidx_q]   = y_clamp;
  end

  // ---------------- sequencer ----------------
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ST_IDLE:    if (accept) state_d = ST_HREAD;
      ST_CLEAR:   if (clr_q == CLW'(CLRN - 1)) state_d = ST_IDLE;
      ST_HREAD:   state_d = ST_HCALC;
      ST_HCALC:   state_d = ST_WREAD;
      ST_WREAD:   state_d = ST_WSUM;
      ST_WSUM:    state_d = ST_SETREAD;
      ST_SETREAD: state_d = ST_DECIDE;
      ST_DECIDE:  state_d = (kind_q == KIND_UPDATE && upd_q && samp_q) ? ST_SREAD : ST_IDLE;
      ST_SREAD:   state_d = ST_SDECIDE;
      ST_SDECIDE: state_d = ST_TREAD;
      ST_TREAD:   state_d = ST_TWRITE;
      ST_TWRITE:  state_d = ST_YREAD;
      ST_YREAD:   state_d = ST_YSUM;
      ST_YSUM:    state_d = ST_SWRITE;
      ST_SWRITE:  state_d = ST_IDLE;
      default:    state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_CLEAR;
      clr_q   <= '0;
    end else begin
      state_q <= state_d;
      if (state_q == ST_CLEAR) clr_q <= clr_q + 1'b1;
    end
  end

  // item capture and datapath
  always_ff @(posedge clk_i) begin
    if (accept) begin
      kind_q <= kind_i;
      upd_q  <= !(is_writeback_i && cache_hit_i);
      tid_q  <= tid_in;
      set_q  <= set_in;
      way_q  <= way_in;
      p_q    <= is_writeback_i ? WB_PC : pc_i;
      tag_q  <= (kind_i == KIND_VICTIM) ? (phys_addr_i >> TAG_SHIFT) : line_tag_i;
      samp_q <= (32'(set_in) % SAMPLE_STRIDE) == 0;
      sset_q <= SSW'(32'(set_in) / SAMPLE_STRIDE);
    end
    if (state_q == ST_HREAD) hist_q <= hist_mem[tid_q];
    if (state_q == ST_HCALC) h_q <= h_calc;
    if (state_q == ST_WREAD || state_q == ST_YREAD)
      for (int f = 0; f < FEATS; f++) w_q[f] <= wt_mem[f][h_q[f]];
    if (state_q == ST_WSUM || state_q == ST_YSUM) sum_q <= sum_calc;
    if (state_q == ST_SETREAD) begin
      lru_q  <= lru_mem[set_q];
      dead_q <= dead_mem[set_q];
    end
    if (state_q == ST_SREAD) begin
      srow_q  <= smp_mem[sset_q];
      sfull_q <= sfull_mem[sset_q];
    end
    if (state_q == ST_SDECIDE) begin
      if (s_hit) begin
        sidx_q   <= s_hidx;
        th_q     <= srow_q.hashes[s_hidx];
        sdir_q   <= 1'b0;
        strain_q <= (srow_q.lru[s_hidx] < SWW'(SAMPLER_WAYS - 1)) &&
                    (signed'(srow_q.outp[s_hidx]) > -theta);
      end else if (!sfull_q && s_inv) begin
        sidx_q   <= s_iidx;
        sdir_q   <= 1'b0;
        strain_q <= 1'b0;
      end else begin
        sidx_q   <= s_lidx;
        th_q     <= srow_q.hashes[s_lidx];
        sdir_q   <= 1'b1;
        strain_q <= (signed'(srow_q.outp[s_lidx]) < theta) ||
                    (signed'(srow_q.outp[s_lidx]) < 10'(repl_q));
      end
    end
    if (state_q == ST_TREAD)
      for (int f = 0; f < FEATS; f++) w_q[f] <= wt_mem[f][th_q[f]];
  end

  // memory writes
  always_ff @(posedge clk_i) begin
    if (state_q == ST_CLEAR) begin
      for (int i = 0; i < WAYS; i++) begin
        if (32'(clr_q) < NUM_SETS) begin
          lru_mem[SETW'(clr_q)][i] <= WYW'(i);
          dead_mem[SETW'(clr_q)][i] <= 1'b0;
        end
      end
      if (32'(clr_q) < TABLE_ENTRIES)
        for (int f = 0; f < FEATS; f++) wt_mem[f][TBW'(clr_q)] <= '0;
      if (32'(clr_q) < SSETS) begin
        for (int i = 0; i < SAMPLER_WAYS; i++) begin
          smp_mem[SSW'(clr_q)].valid[i]  <= 1'b0;
          smp_mem[SSW'(clr_q)].outp[i]   <= '0;
          smp_mem[SSW'(clr_q)].hashes[i] <= '0;
          smp_mem[SSW'(clr_q)].lru[i]    <= SWW'(i);
          smp_mem[SSW'(clr_q)].tag[i]    <= '0;
        end
        sfull_mem[SSW'(clr_q)] <= 1'b0;
      end
      if (32'(clr_q) < THREADS) hist_mem[THW'(clr_q)] <= '0;
    end
    if (state_q == ST_DECIDE && kind_q == KIND_UPDATE) begin
      if (upd_q) begin
        lru_mem[set_q] <= lru_new;
        dead_mem[set_q][way_q] <= (sum_q >= 10'(repl_q));
      end
      hist_mem[tid_q] <= {hist_q[1], hist_q[0], p_q};
    end
    if (state_q == ST_TWRITE && strain_q)
      for (int f = 0; f < FEATS; f++) wt_mem[f][th_q[f]] <= wstep(w_q[f], sdir_q);
    if (state_q == ST_SWRITE) begin
      smp_mem[sset_q] <= srow_new;
      if (!s_hit && !(s_inv)) sfull_mem[sset_q] <= 1'b1;
    end
  end

  // result register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      result_valid_o <= 1'b0;
      victim_way_o   <= '0;
      bypass_o       <= 1'b0;
      dead_victim_o  <= 1'b0;
    end else begin
      result_valid_o <= (state_q == ST_DECIDE);
      if (state_q == ST_DECIDE) begin
        if (kind_q == KIND_VICTIM && sum_q >= 10'(byp_q)) begin
          victim_way_o  <= '0;
          bypass_o      <= 1'b1;
          dead_victim_o <= 1'b0;
        end else if (kind_q == KIND_VICTIM && dead_found) begin
          victim_way_o  <= 4'(dead_way);
          bypass_o      <= 1'b0;
          dead_victim_o <= 1'b1;
        end else if (kind_q == KIND_VICTIM) begin
          victim_way_o  <= 4'(lru_w);
          bypass_o      <= 1'b0;
          dead_victim_o <= 1'b0;
        end else begin
          victim_way_o  <= '0;
          bypass_o      <= 1'b0;
          dead_victim_o <= 1'b0;
        end
      end
    end
  end

endmodule

FILE: sv/prr_checker.sv
// Port-level checker for the perceptron reuse replacement unit.
// Depends on nothing; bound to the top level below.
module prr_checker (
  input logic       clk_i,
  input logic       rst_ni,
  input logic       start,
  input logic       busy,
  input logic       result_valid_o,
  input logic [3:0] victim_way_o,
  input logic       bypass_o,
  input logic       dead_victim_o
);
  a_acc_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    start && !busy |=> busy) else $error("accept did not raise busy");
  a_byp_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    result_valid_o && bypass_o |-> victim_way_o == 4'd0 && !dead_victim_o)
    else $error("bypass with way");
  a_res_pulse: assert property (@(posedge clk_i) disable iff (!rst_ni)
    result_valid_o |=> !result_valid_o) else $error("result held");
  a_res_end: assert property (@(posedge clk_i) disable iff (!rst_ni)
    result_valid_o && !busy |-> $past(busy)) else $error("result without item");
endmodule

bind perceptron_reuse_replacement_unit prr_checker u_prr_checker (.*);

FILE: sim/tb_perceptron_reuse_replacement_unit.sv
// Self-checking testbench for perceptron_reuse_replacement_unit.
// Depends on prr_pkg and the unit's RTL; the expected victim, bypass and dead flags
// come from a predictor kept in this file.
module tb_perceptron_reuse_replacement_unit;
  timeunit 1ns;
  timeprecision 1ps;
  import prr_pkg::*;

  localparam int NSETS   = 1024;
  localparam int NWAYS   = 16;
  localparam int TBL     = 256;
  localparam int SWAYS   = 16;
  localparam int NTHR    = 16;
  localparam int STRIDE  = 16;
  localparam int SSETS   = NSETS / STRIDE;
  localparam int HOT_SETS = 4;     // sampled sets hammered by the random part
  localparam int TAG_POOL = 24;    // more tags than sampler ways, so sets evict
  localparam int WDOG_LIMIT = 20000;

  typedef logic [7:0] hvec_t [FEATS];

  // One result item.
  typedef struct {
    logic [3:0] victim;
    logic       byp;
    logic       dead;
  } outcome_t;

  // One row of the directed table; typed rows carry their outcome.
  typedef struct {
    logic        kind;
    logic [3:0]  tid;
    logic [9:0]  set;
    logic [3:0]  way;
    logic [63:0] pc;
    logic [63:0] addr;
    logic [63:0] tag;
    logic        wb;
    logic        hit;
    bit          typed;
    outcome_t    res;
  } row_t;

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        start = 1'b0;
  logic        busy;
  logic        cfg_valid_i = 1'b0;
  logic        cfg_ready_o;
  logic [1:0]  cfg_index_i = '0;
  logic [8:0]  cfg_data_i = '0;
  logic        kind_i = 1'b0;
  logic [3:0]  thread_id_i = '0;
  logic [9:0]  set_index_i = '0;
  logic [3:0]  way_i = '0;
  logic [63:0] pc_i = '0;
  logic [63:0] phys_addr_i = '0;
  logic [63:0] line_tag_i = '0;
  logic        is_writeback_i = 1'b0;
  logic        cache_hit_i = 1'b0;
  logic        result_valid_o;
  logic [3:0]  victim_way_o;
  logic        bypass_o;
  logic        dead_victim_o;

  perceptron_reuse_replacement_unit DUT (.*);

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  // ---------------------------------------------------------------------------
  // Predictor state: its own copy of the registers and every table.
  // ---------------------------------------------------------------------------
  int          margin_r, repl_thr, byp_thr;
  int          line_lru [NSETS][NWAYS];
  bit          line_dead [NSETS][NWAYS];
  byte         wts [FEATS][TBL];
  logic [63:0] pc_hist [NTHR][3];
  logic [63:0] smp_tag [SSETS][SWAYS];
  bit          smp_vld [SSETS][SWAYS];
  int          smp_y [SSETS][SWAYS];
  hvec_t       smp_h [SSETS][SWAYS];
  int          smp_lru [SSETS][SWAYS];
  bit          smp_full [SSETS];

  outcome_t    verdict_q [$];
  bit          failed = 1'b0;
  bit          typed_now = 1'b0;
  outcome_t    typed_res;
  int          idle_cycles = 0;
  logic [63:0] tag_pool [HOT_SETS][TAG_POOL];
  logic [63:0] pc_pool [8];

  initial begin
    margin_r = 68; repl_thr = 124; byp_thr = 3;
    for (int s = 0; s < NSETS; s++)
      for (int w = 0; w < NWAYS; w++) begin
        line_lru[s][w] = w; line_dead[s][w] = 0;
      end
    foreach (wts[f, i]) wts[f][i] = 0;
    foreach (pc_hist[t, k]) pc_hist[t][k] = '0;
    for (int s = 0; s < SSETS; s++) begin
      smp_full[s] = 0;
      for (int w = 0; w < SWAYS; w++) begin
        smp_tag[s][w] = '0; smp_vld[s][w] = 0; smp_y[s][w] = 0; smp_lru[s][w] = w;
        for (int f = 0; f < FEATS; f++) smp_h[s][w][f] = '0;
      end
    end
  end

  // Feature indexes: each one is the low byte of PC xor a shifted PC, history entry or tag.
  function automatic hvec_t feature_idx(int tid, logic [63:0] p, logic [63:0] tg);
    hvec_t h;
    h[0] = p[7:0] ^ p[9:2];
    h[1] = p[7:0] ^ pc_hist[tid][0][8:1];
    h[2] = p[7:0] ^ pc_hist[tid][1][9:2];
    h[3] = p[7:0] ^ pc_hist[tid][2][10:3];
    h[4] = p[7:0] ^ tg[11:4];
    h[5] = p[7:0] ^ tg[7:0];
    return h;
  endfunction

  function automatic int reuse_sum(hvec_t h);
    int s = 0;
    for (int f = 0; f < FEATS; f++) s += wts[f][h[f]];
    return s;
  endfunction

  function automatic void nudge_weights(hvec_t h, bit up);
    for (int f = 0; f < FEATS; f++)
      if (up) wts[f][h[f]] = (wts[f][h[f]] < 32) ? wts[f][h[f]] + 1 : 32;
      else    wts[f][h[f]] = (wts[f][h[f]] > -32) ? wts[f][h[f]] - 1 : -32;
  endfunction

  // Move way w of a set to MRU; positions above it age by one.
  function automatic void line_promote(int s, int w);
    int cur = line_lru[s][w];
    for (int i = 0; i < NWAYS; i++) if (line_lru[s][i] < cur) line_lru[s][i]++;
    line_lru[s][w] = 0;
  endfunction

  function automatic void smp_promote(int s, int w);
    int cur = smp_lru[s][w];
    for (int i = 0; i < SWAYS; i++) if (smp_lru[s][i] < cur) smp_lru[s][i]++;
    smp_lru[s][w] = 0;
  endfunction

  function automatic void sampler_touch(int s, logic [63:0] tg, hvec_t h);
    int i, y;
    bit found = 0;
    for (i = 0; i < SWAYS; i++)
      if (smp_vld[s][i] && smp_tag[s][i] == tg) begin
        found = 1; break;
      end
    if (found) begin
      // hit on a line not yet at LRU: it was reused, train toward live
      if (smp_lru[s][i] < SWAYS - 1 && smp_y[s][i] > -margin_r)
        nudge_weights(smp_h[s][i], 1'b0);
    end else begin
      if (!smp_full[s]) begin
        for (i = 0; i < SWAYS; i++) if (!smp_vld[s][i]) break;
        if (i == SWAYS) smp_full[s] = 1;
      end
      if (smp_full[s]) begin
        // evict the sampler LRU line; it died unused, train toward dead
        for (i = 0; i < SWAYS; i++) if (smp_lru[s][i] == SWAYS - 1) break;
        if (i == SWAYS) i = 0;
        else if (smp_y[s][i] < margin_r || smp_y[s][i] < repl_thr)
          nudge_weights(smp_h[s][i], 1'b1);
      end
    end
    smp_promote(s, i);
    smp_tag[s][i] = tg;
    smp_vld[s][i] = 1;
    smp_h[s][i] = h;
    y = reuse_sum(h);
    if (y > 255) y = 255;
    if (y < -256) y = -256;
    smp_y[s][i] = y;
  endfunction

  // Works out the result of the item on the ports and advances the state.
  function automatic outcome_t predict_replacement();
    outcome_t    r = '{victim: '0, byp: 1'b0, dead: 1'b0};
    int          tid = thread_id_i, s = set_index_i, w = way_i;
    logic [63:0] p = is_writeback_i ? WB_PC : pc_i;
    hvec_t       h;
    bit          done = 0;
    if (kind_i == KIND_VICTIM) begin
      h = feature_idx(tid, p, phys_addr_i >> TAG_SHIFT);
      if (reuse_sum(h) >= byp_thr) r.byp = 1'b1;
      else begin
        for (int i = 0; i < NWAYS; i++)
          if (!done && line_dead[s][i]) begin
            r.victim = 4'(i); r.dead = 1'b1; done = 1;
          end
        for (int i = 0; i < NWAYS; i++)
          if (!done && line_lru[s][i] == NWAYS - 1) begin
            r.victim = 4'(i); done = 1;
          end
      end
      return r;
    end
    // writeback hits leave LRU, dead marks and the sampler alone
    if (!(is_writeback_i && cache_hit_i)) begin
      line_promote(s, w);
      h = feature_idx(tid, p, line_tag_i);
      line_dead[s][w] = reuse_sum(h) >= repl_thr;
      if (s % STRIDE == 0) sampler_touch(s / STRIDE, line_tag_i, h);
    end
    pc_hist[tid][2] = pc_hist[tid][1];
    pc_hist[tid][1] = pc_hist[tid][0];
    pc_hist[tid][0] = p;
    return r;
  endfunction

  // ---------------------------------------------------------------------------
  // Monitor: predicts on item acceptance, checks each strobed result.
  // ---------------------------------------------------------------------------
  always @(posedge clk_i) begin
    outcome_t e, got;
    bit moved;
    moved = 1'b0;
    if (rst_ni) begin
      if (start && !busy) begin
        e = predict_replacement();
        if (typed_now) e = typed_res;
        verdict_q.push_back(e);
        moved = 1'b1;
      end
      if (cfg_valid_i && cfg_ready_o) moved = 1'b1;
      if (result_valid_o) begin
        moved = 1'b1;
        got = '{victim: victim_way_o, byp: bypass_o, dead: dead_victim_o};
        if (verdict_q.size() == 0) begin
          failed = 1'b1;
          $display("%0t: unexpected result way=%0d byp=%0b dead=%0b",
                   $time, got.victim, got.byp, got.dead);
        end else begin
          e = verdict_q.pop_front();
          if (got.victim !== e.victim) begin
            failed = 1'b1;
            $display("%0t: victim_way expected %0d got %0d", $time, e.victim, got.victim);
          end
          if (got.byp !== e.byp) begin
            failed = 1'b1;
            $display("%0t: bypass expected %0b got %0b", $time, e.byp, got.byp);
          end
          if (got.dead !== e.dead) begin
            failed = 1'b1;
            $display("%0t: dead_victim expected %0b got %0b", $time, e.dead, got.dead);
          end
        end
      end
      idle_cycles <= moved ? 0 : idle_cycles + 1;
    end
  end

  // Watchdog: too long with no item, result or register write moving.
  always @(posedge clk_i) begin
    if (idle_cycles >= WDOG_LIMIT) begin
      $display("TEST FAILED");
      $finish;
    end
  end

  // ---------------------------------------------------------------------------
  // Stimulus.
  // ---------------------------------------------------------------------------
  task automatic send_item(row_t r, int gap_pct);
    if ($urandom_range(99) < gap_pct) begin
      start = 1'b0;
      repeat ($urandom_range(1, 6)) @(negedge clk_i);
    end
    kind_i = r.kind; thread_id_i = r.tid; set_index_i = r.set; way_i = r.way;
    pc_i = r.pc; phys_addr_i = r.addr; line_tag_i = r.tag;
    is_writeback_i = r.wb; cache_hit_i = r.hit;
    typed_now = r.typed; typed_res = r.res;
    start = 1'b1;
    do @(posedge clk_i); while (busy);
    @(negedge clk_i);
  endtask

  task automatic write_reg(logic [1:0] idx, int val);
    cfg_index_i = idx; cfg_data_i = val[8:0]; cfg_valid_i = 1'b1;
    do @(posedge clk_i); while (!cfg_ready_o);
    case (idx)
      REG_MARGIN:  margin_r = val & 8'hFF;
      REG_REPLACE: repl_thr = val;
      default:     byp_thr = val;
    endcase
    @(negedge clk_i);
    cfg_valid_i = 1'b0;
  endtask

  // Block is idle: every result in and busy low.
  task automatic drain();
    start = 1'b0;
    while (verdict_q.size() != 0 || busy) @(negedge clk_i);
  endtask

  function automatic logic [63:0] rnd64();
    return {$urandom(), $urandom()};
  endfunction

  // Random item: many sampled-set updates over a reused tag pool, so the
  // sampler fills, hits and evicts and the weights move; the rest are updates of random sets and victim requests.
  function automatic row_t random_item();
    row_t r;
    int   hs = $urandom_range(HOT_SETS - 1);
    int   sel = $urandom_range(99);
    r.tid = ($urandom_range(3) == 0) ? 4'($urandom()) : 4'($urandom_range(2));
    r.way = 4'($urandom());
    r.pc = ($urandom_range(4) == 0) ? rnd64() : pc_pool[$urandom_range(7)];
    r.wb = ($urandom_range(9) == 0);
    r.hit = 1'($urandom_range(1));
    r.typed = 0;
    r.res = '{victim: '0, byp: 1'b0, dead: 1'b0};
    r.addr = rnd64();
    r.tag = rnd64();
    if (sel < 45) begin
      r.kind = KIND_UPDATE; r.set = 10'(hs * STRIDE);
      r.tag = tag_pool[hs][$urandom_range(TAG_POOL - 1)];
    end else if (sel < 60) begin
      r.kind = KIND_UPDATE; r.set = 10'($urandom());
    end else begin
      r.kind = KIND_VICTIM;
      r.set = ($urandom_range(1)) ? 10'(hs * STRIDE) : 10'($urandom());
      if ($urandom_range(1))
        r.addr = {tag_pool[hs][$urandom_range(TAG_POOL - 1)][45:0], 18'($urandom())};
    end
    return r;
  endfunction

  // Directed rows: reset state, field extremes, writeback hit and the first
  // sampler fill/hit; rows whose outcome needs the weights use the predictor.
  localparam outcome_t ZERO = '{victim: 4'd0, byp: 1'b0, dead: 1'b0};
  localparam outcome_t LRU15 = '{victim: 4'd15, byp: 1'b0, dead: 1'b0};
  localparam outcome_t LRU14 = '{victim: 4'd14, byp: 1'b0, dead: 1'b0};
  row_t directed [] = '{
    '{KIND_VICTIM, 4'd0, 10'd5, 4'd0, 64'h0, 64'h0, 64'h0, 1'b0, 1'b0, 1, LRU15},
    '{KIND_VICTIM, 4'd15, 10'd1023, 4'd15, '1, '1, '1, 1'b0, 1'b0, 1, LRU15},
    '{KIND_UPDATE, 4'd15, 10'd1023, 4'd15, '1, '1, '1, 1'b0, 1'b0, 1, ZERO},
    '{KIND_VICTIM, 4'd15, 10'd1023, 4'd0, '1, '1, '1, 1'b0, 1'b0, 1, LRU14},
    '{KIND_UPDATE, 4'd3, 10'd1023, 4'd14, 64'h40, 64'h0, 64'h9, 1'b1, 1'b1, 1, ZERO},
    '{KIND_VICTIM, 4'd3, 10'd1023, 4'd0, 64'h40, 64'h0, 64'h0, 1'b0, 1'b0, 1, LRU14},
    '{KIND_UPDATE, 4'd1, 10'd0, 4'd3, 64'h1234, 64'h0, 64'hA5, 1'b0, 1'b0, 1, ZERO},
    '{KIND_UPDATE, 4'd1, 10'd0, 4'd4, 64'h1234, 64'h0, 64'hA5, 1'b0, 1'b1, 1, ZERO},
    '{KIND_UPDATE, 4'd1, 10'd0, 4'd4, 64'h1234, 64'h0, 64'hA5, 1'b0, 1'b1, 1, ZERO},
    '{KIND_VICTIM, 4'd1, 10'd0, 4'd0, 64'h1234, 64'hA5 << 18, 64'h0, 1'b0, 1'b0, 0, ZERO},
    '{KIND_UPDATE, 4'd2, 10'd16, 4'd7, 64'h0, 64'h0, 64'h0, 1'b1, 1'b0, 1, ZERO},
    '{KIND_UPDATE, 4'd2, 10'd16, 4'd7, 64'h0, 64'h0, 64'h0, 1'b1, 1'b0, 1, ZERO},
    '{KIND_VICTIM, 4'd2, 10'd16, 4'd0, 64'h0, 64'h0, 64'h0, 1'b1, 1'b0, 0, ZERO},
    '{KIND_VICTIM, 4'd8, 10'd512, 4'd9, '1, '1, '1, 1'b1, 1'b1, 0, ZERO}
  };

  // Register settings per random phase: margin, replace, bypass.
  int settings [6][3] = '{
    '{68, 124, 3}, '{255, 255, 255}, '{0, -256, -256},
    '{10, 0, 20}, '{128, 30, -5}, '{5, -10, 10}
  };

  initial begin
    for (int s = 0; s < HOT_SETS; s++)
      for (int k = 0; k < TAG_POOL; k++) tag_pool[s][k] = rnd64();
    foreach (pc_pool[k]) pc_pool[k] = rnd64();

    repeat (9) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    foreach (directed[k]) send_item(directed[k], 0);
    drain();

    for (int ph = 0; ph < 6; ph++) begin
      write_reg(REG_MARGIN, settings[ph][0]);
      write_reg(REG_REPLACE, settings[ph][1]);
      write_reg(REG_BYPASS, settings[ph][2]);
      // sender idling: light, then heavy, then none
      for (int n = 0; n < 125; n++)
        send_item(random_item(), (ph < 2) ? 24 : (ph < 4) ? 73 : 0);
      drain();
    end

    repeat (40) @(negedge clk_i);
    if (!failed && verdict_q.size() == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

endmodule
